// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Operation and error codes, the per-chain shift command and the control
// bundle that each storage cell receives.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned OP_W    = 3;
	localparam int unsigned COUNT_W = 5;

	// Value reported at either end when nothing is held
	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

	// Operation codes; codes above OP_QUERY act as a query
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_QUERY      = 3'd4
	} op_code_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNDERFLOW = 2'd2
	} err_code_t;

	// Command applied to a whole row of cells
	typedef enum logic [1:0] {
		CH_HOLD,    // keep contents
		CH_PUSH,    // shift towards the tail, new value enters cell 0
		CH_POP,     // shift towards cell 0, cell 0 is discarded
		CH_APPEND   // write new value into the first unused cell
	} chain_op_t;

	// Control seen by one cell
	typedef struct packed {
		chain_op_t op;
		logic      at_tail;   // this cell is the first unused one
	} cell_ctrl_t;

endpackage

// ===== rtl/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of a row
// Holds one entry and takes its next value from itself, from either
// neighbour or from the incoming value, as the row command says.
// ----------------------------------------------------------------------------
module dq_cell (
	input  logic                               clk,
	input  dq_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [dq_pkg::DATA_W-1:0]   value,
	input  logic signed [dq_pkg::DATA_W-1:0]   lower_data,
	input  logic signed [dq_pkg::DATA_W-1:0]   upper_data,
	output logic signed [dq_pkg::DATA_W-1:0]   data_q
);

	logic signed [dq_pkg::DATA_W-1:0] data_d;

	// next entry selection
	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			dq_pkg::CH_HOLD:   data_d = data_q;
			dq_pkg::CH_PUSH:   data_d = lower_data;
			dq_pkg::CH_POP:    data_d = upper_data;
			dq_pkg::CH_APPEND: data_d = ctrl.at_tail ? value : data_q;
			default:           data_d = data_q;
		endcase
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

// ===== rtl/dq_chain.sv =====
// ----------------------------------------------------------------------------
// dq_chain: row of storage cells seen from one end of the queue
// Cell 0 is the end this row serves; cell k is the k-th entry from it.
// Occupancy follows from the shared count, so each cell only compares
// its own index against it.
// ----------------------------------------------------------------------------
module dq_chain #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned CW    = 5
) (
	input  logic                               clk,
	input  dq_pkg::chain_op_t                  op,
	input  logic [CW-1:0]                      count,
	input  logic signed [dq_pkg::DATA_W-1:0]   value,
	output logic signed [dq_pkg::DATA_W-1:0]   head_data,
	output logic signed [dq_pkg::DATA_W-1:0]   next_data
);

	logic signed [dq_pkg::DATA_W-1:0] data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dq_pkg::cell_ctrl_t               ctrl;
		logic signed [dq_pkg::DATA_W-1:0] lower;
		logic signed [dq_pkg::DATA_W-1:0] upper;

		assign ctrl.op      = op;
		assign ctrl.at_tail = (count == CW'(i));

		// neighbour taps; the ends feed in the new value or themselves
		if (i == 0) begin : g_first
			assign lower = value;
		end else begin : g_mid_lo
			assign lower = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = data[i];
		end else begin : g_mid_hi
			assign upper = data[i+1];
		end

		dq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.value      (value),
			.lower_data (lower),
			.upper_data (upper),
			.data_q     (data[i])
		);
	end

	assign head_data = data[0];
	assign next_data = data[1];

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: deque of signed 32-bit values on two rows of cells
// One row keeps the entries ordered from the front, the other from the
// rear, so both ends always sit in a fixed cell and every change is a
// neighbour shift or a single append.
//
//   channel  direction  handshake            payload
//   in       in         in_valid / in_stall  op, value
//   out      out        out_valid/ out_stall front_value, rear_value,
//                                           is_empty, is_full,
//                                           entry_count, error_code
//
// One transaction per cycle while in_stall is low; its result is registered
// and appears in the cycle after acceptance. The result register loads
// alongside the shift of both cell rows, from the ends decoded before it.
// Reset clears the count and the result valid; cell contents are not reset.
// in_stall rises only while a held result is stalled at the output.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [dq_pkg::OP_W-1:0]            op,
	input  logic signed [dq_pkg::DATA_W-1:0]   value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dq_pkg::DATA_W-1:0]   front_value,
	output logic signed [dq_pkg::DATA_W-1:0]   rear_value,
	output logic                               is_empty,
	output logic                               is_full,
	output logic [dq_pkg::COUNT_W-1:0]         entry_count,
	output logic [1:0]                         error_code
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    count_d;
	logic                             accept;
	logic                             full;
	logic                             empty;
	dq_pkg::chain_op_t                front_op;
	dq_pkg::chain_op_t                rear_op;
	logic signed [dq_pkg::DATA_W-1:0] f0, f1, r0, r1;
	logic signed [dq_pkg::DATA_W-1:0] front_d, rear_d;
	dq_pkg::err_code_t                err_d;

	logic                             out_valid_q;
	logic signed [dq_pkg::DATA_W-1:0] front_q, rear_q;
	logic                             empty_q, full_q;
	logic [dq_pkg::COUNT_W-1:0]       count_out_q;
	dq_pkg::err_code_t                err_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	// operation decode: row commands, new count, error code, ends after the operation
	always_comb begin
		front_op = dq_pkg::CH_HOLD;
		rear_op  = dq_pkg::CH_HOLD;
		count_d  = count_q;
		err_d    = dq_pkg::ERR_OK;
		front_d  = f0;
		rear_d   = r0;
		case (op)
			dq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					err_d = dq_pkg::ERR_OVERFLOW;
				end else begin
					front_op = dq_pkg::CH_PUSH;
					rear_op  = dq_pkg::CH_APPEND;
					count_d  = count_q + 1'b1;
					front_d  = value;
					rear_d   = empty ? value : r0;
				end
			end
			dq_pkg::OP_PUSH_REAR: begin
				if (full) begin
					err_d = dq_pkg::ERR_OVERFLOW;
				end else begin
					front_op = dq_pkg::CH_APPEND;
					rear_op  = dq_pkg::CH_PUSH;
					count_d  = count_q + 1'b1;
					front_d  = empty ? value : f0;
					rear_d   = value;
				end
			end
			dq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					err_d = dq_pkg::ERR_UNDERFLOW;
				end else begin
					front_op = dq_pkg::CH_POP;
					count_d  = count_q - 1'b1;
					front_d  = f1;
				end
			end
			dq_pkg::OP_POP_REAR: begin
				if (empty) begin
					err_d = dq_pkg::ERR_UNDERFLOW;
				end else begin
					rear_op = dq_pkg::CH_POP;
					count_d = count_q - 1'b1;
					rear_d  = r1;
				end
			end
			default: begin
				// query and unused codes change nothing
			end
		endcase
		if (count_d == '0) begin
			front_d = dq_pkg::EMPTY_VALUE;
			rear_d  = dq_pkg::EMPTY_VALUE;
		end
		if (!accept) begin
			front_op = dq_pkg::CH_HOLD;
			rear_op  = dq_pkg::CH_HOLD;
		end
	end

	// row ordered from the front
	dq_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_front_chain (
		.clk       (clk),
		.op        (front_op),
		.count     (count_q),
		.value     (value),
		.head_data (f0),
		.next_data (f1)
	);

	// row ordered from the rear
	dq_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_rear_chain (
		.clk       (clk),
		.op        (rear_op),
		.count     (count_q),
		.value     (value),
		.head_data (r0),
		.next_data (r1)
	);

	// occupancy count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			front_q     <= front_d;
			rear_q      <= rear_d;
			empty_q     <= (count_d == '0);
			full_q      <= (count_d == CW'(DEPTH));
			count_out_q <= dq_pkg::COUNT_W'(count_d);
			err_q       <= err_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign front_value = front_q;
	assign rear_value  = rear_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;
	assign entry_count = count_out_q;
	assign error_code  = err_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy count beyond depth");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("empty and full reported together");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == dq_pkg::ERR_OVERFLOW) |-> is_full)
		else $error("overflow reported while not full");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == dq_pkg::ERR_UNDERFLOW) |-> is_empty)
		else $error("underflow reported while not empty");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted transaction gave no result");

endmodule
